[sv/cwc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package cwc_pkg;
  localparam int COORD_BITS  = 20;
  localparam int SIZE_BITS   = 18;
  localparam int RADIUS_BITS = 16;
  localparam int COUNT_BITS  = 4;
  localparam int SLOT_BITS   = 3;
  localparam int MAX_WALLS   = 8;
  localparam int ADDR_BITS   = 5;
  localparam int DATA_BITS   = 32;

  typedef enum logic [2:0] {
    REG_RADIUS = 3'd0,
    REG_LEFT   = 3'd1,
    REG_RIGHT  = 3'd2,
    REG_TOP    = 3'd3,
    REG_BOTTOM = 3'd4,
    REG_WALLS  = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic        [RADIUS_BITS-1:0] radius;
    logic signed [COORD_BITS-1:0]  left;
    logic signed [COORD_BITS-1:0]  right;
    logic signed [COORD_BITS-1:0]  top;
    logic signed [COORD_BITS-1:0]  bottom;
    logic        [COUNT_BITS-1:0]  walls;
  } cfg_t;
endpackage
`default_nettype wire

[sv/cwc_if.sv]
`timescale 1ns / 1ps
`default_nettype none
interface cwc_in_if;
  import cwc_pkg::*;
  logic                         valid;
  logic                         ready;
  logic                         kind;
  logic        [SLOT_BITS-1:0]  wall_slot;
  logic signed [COORD_BITS-1:0] wall_x;
  logic signed [COORD_BITS-1:0] wall_y;
  logic        [SIZE_BITS-1:0]  wall_w;
  logic        [SIZE_BITS-1:0]  wall_h;
  logic signed [COORD_BITS-1:0] centre_x;
  logic signed [COORD_BITS-1:0] centre_y;
  modport source (output valid, kind, wall_slot, wall_x, wall_y, wall_w, wall_h,
                  centre_x, centre_y, input ready);
  modport sink (input valid, kind, wall_slot, wall_x, wall_y, wall_w, wall_h,
                centre_x, centre_y, output ready);
endinterface

interface cwc_out_if;
  import cwc_pkg::*;
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] resolved_x;
  logic signed [COORD_BITS-1:0] resolved_y;
  modport source (output valid, resolved_x, resolved_y, input ready);
  modport sink (input valid, resolved_x, resolved_y, output ready);
endinterface
`default_nettype wire

[sv/cwc_cfg.sv]
`timescale 1ns / 1ps
`default_nettype none
module cwc_cfg (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [cwc_pkg::ADDR_BITS-1:0] paddr,
  input  wire logic [cwc_pkg::DATA_BITS-1:0] pwdata,
  output logic      [cwc_pkg::DATA_BITS-1:0] prdata,
  output logic                               pready,
  output cwc_pkg::cfg_t                      cfg
);
  import cwc_pkg::*;

  cfg_t     cfg_r;
  reg_idx_t idx;
  logic     wr;

  assign idx    = reg_idx_t'(paddr[ADDR_BITS-1:2]);
  assign wr     = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.radius <= RADIUS_BITS'(320);
      cfg_r.left   <= '0;
      cfg_r.right  <= COORD_BITS'(30720);
      cfg_r.top    <= '0;
      cfg_r.bottom <= COORD_BITS'(17280);
      cfg_r.walls  <= '0;
    end else if (wr) begin
      case (idx)
        REG_RADIUS: cfg_r.radius <= pwdata[RADIUS_BITS-1:0];
        REG_LEFT:   cfg_r.left   <= pwdata[COORD_BITS-1:0];
        REG_RIGHT:  cfg_r.right  <= pwdata[COORD_BITS-1:0];
        REG_TOP:    cfg_r.top    <= pwdata[COORD_BITS-1:0];
        REG_BOTTOM: cfg_r.bottom <= pwdata[COORD_BITS-1:0];
        REG_WALLS:  cfg_r.walls  <= pwdata[COUNT_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_RADIUS: prdata = DATA_BITS'(cfg_r.radius);
      REG_LEFT:   prdata = DATA_BITS'(unsigned'(cfg_r.left));
      REG_RIGHT:  prdata = DATA_BITS'(unsigned'(cfg_r.right));
      REG_TOP:    prdata = DATA_BITS'(unsigned'(cfg_r.top));
      REG_BOTTOM: prdata = DATA_BITS'(unsigned'(cfg_r.bottom));
      REG_WALLS:  prdata = DATA_BITS'(cfg_r.walls);
      default:    prdata = '0;
    endcase
  end
endmodule
`default_nettype wire

[sv/circle_wall_collision_resolve.sv]
`timescale 1ns / 1ps
// A load request writes one wall slot. A resolve request visits each wall in turn;
// a wall can be dropped on the axis test or on the distance test before it pushes.
// Work is done by one shared 17x17 multiplier, a 16-step square root and a 34-step
// restoring divider in turn; the result goes valid in the same cycle the block goes idle.
// One request at a time; a waiting result holds a finished resolve at its last step.
// Synchronous active-low reset restores register defaults; wall table unset until loaded.
`default_nettype none
module circle_wall_collision_resolve (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  cwc_in_if.sink                             in_ch,
  cwc_out_if.source                          out_ch,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [cwc_pkg::ADDR_BITS-1:0] paddr,
  input  wire logic [cwc_pkg::DATA_BITS-1:0] pwdata,
  output logic      [cwc_pkg::DATA_BITS-1:0] prdata,
  output logic                               pready
);
  import cwc_pkg::*;

  localparam int PW = COORD_BITS + 4;   // working centre
  localparam int DW = PW + 1;           // offset to nearest point
  localparam int MW = 2 * (RADIUS_BITS + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_WALL, S_CHK, S_SQX, S_SQY, S_SUM, S_CMP, S_SQRT,
    S_MUL, S_DSET, S_DIV, S_APPLY, S_BORD, S_DONE
  } state_t;

  cfg_t cfg;
  cwc_cfg u_cfg (
    .clk, .rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .cfg
  );

  logic signed [COORD_BITS-1:0] wl_mem [MAX_WALLS];
  logic signed [COORD_BITS-1:0] wt_mem [MAX_WALLS];
  logic        [SIZE_BITS-1:0]  ww_mem [MAX_WALLS];
  logic        [SIZE_BITS-1:0]  wh_mem [MAX_WALLS];

  state_t                       state_r;
  logic signed [PW-1:0]         px_r, py_r;
  logic signed [DW-1:0]         dx_r, dy_r;
  logic        [SLOT_BITS:0]    wi_r;
  logic                         axis_r;
  logic        [MW-1:0]         prod_r, acc_r, num_r;
  logic        [31:0]           sq_src_r;
  logic        [RADIUS_BITS+1:0] sq_rem_r;
  logic        [RADIUS_BITS-1:0] root_r;
  logic        [RADIUS_BITS:0]  drem_r;
  logic        [5:0]            cnt_r;
  logic                         ov_r;
  logic signed [COORD_BITS-1:0] rx_r, ry_r;

  // Combinational helpers
  logic        [SLOT_BITS:0]    n_walls;
  logic        [SLOT_BITS-1:0]  wsel;
  logic signed [PW-1:0]         lo_x, hi_x, lo_y, hi_y, nx, ny;
  logic        [DW-1:0]         ax, ay;
  logic        [RADIUS_BITS:0]  mul_a, mul_b, ovl;
  logic        [RADIUS_BITS+1:0] sq_sh, sq_trial;
  logic        [RADIUS_BITS:0]  d_sh;
  logic signed [DW-1:0]         rad_s, kx, ky;
  logic signed [PW-1:0]         q_s;
  logic                         out_free;

  assign n_walls = (cfg.walls > COUNT_BITS'(MAX_WALLS)) ? (SLOT_BITS+1)'(MAX_WALLS)
                                                        : cfg.walls;
  assign wsel = wi_r[SLOT_BITS-1:0];
  assign lo_x = PW'(wl_mem[wsel]);
  assign hi_x = lo_x + PW'(signed'({1'b0, ww_mem[wsel]}));
  assign lo_y = PW'(wt_mem[wsel]);
  assign hi_y = lo_y + PW'(signed'({1'b0, wh_mem[wsel]}));
  assign nx = (px_r < lo_x) ? lo_x : ((px_r > hi_x) ? hi_x : px_r);
  assign ny = (py_r < lo_y) ? lo_y : ((py_r > hi_y) ? hi_y : py_r);
  assign ax = dx_r[DW-1] ? DW'(-dx_r) : DW'(dx_r);
  assign ay = dy_r[DW-1] ? DW'(-dy_r) : DW'(dy_r);
  assign ovl = {1'b0, cfg.radius} - {1'b0, root_r};
  assign rad_s = DW'(signed'({1'b0, cfg.radius}));
  assign q_s = PW'(num_r);
  assign out_free = !ov_r || out_ch.ready;

  always_comb begin
    case (state_r)
      S_SQX:   begin mul_a = ax[RADIUS_BITS:0]; mul_b = ax[RADIUS_BITS:0]; end
      S_SQY:   begin mul_a = ay[RADIUS_BITS:0]; mul_b = ay[RADIUS_BITS:0]; end
      S_SUM:   begin mul_a = {1'b0, cfg.radius}; mul_b = {1'b0, cfg.radius}; end
      S_MUL:   begin
        mul_a = axis_r ? ay[RADIUS_BITS:0] : ax[RADIUS_BITS:0];
        mul_b = ovl;
      end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  assign sq_sh    = {sq_rem_r[RADIUS_BITS-1:0], sq_src_r[31:30]};
  assign sq_trial = {root_r, 2'b01};
  assign d_sh     = {drem_r[RADIUS_BITS-1:0], num_r[MW-1]};

  // Keep the centre one radius clear of the border
  always_comb begin
    logic signed [DW-1:0] pxe, pye;
    pxe = DW'(px_r);
    pye = DW'(py_r);
    if (pxe - rad_s < DW'(cfg.left))        kx = DW'(cfg.left) + rad_s;
    else if (pxe + rad_s > DW'(cfg.right))  kx = DW'(cfg.right) - rad_s;
    else                                    kx = pxe;
    if (pye - rad_s < DW'(cfg.top))         ky = DW'(cfg.top) + rad_s;
    else if (pye + rad_s > DW'(cfg.bottom)) ky = DW'(cfg.bottom) - rad_s;
    else                                    ky = pye;
  end

  localparam logic signed [DW-1:0] SAT_HI = DW'((1 << (COORD_BITS-1)) - 1);
  localparam logic signed [DW-1:0] SAT_LO = -DW'(1 << (COORD_BITS-1));

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_ch.valid && !in_ch.kind) begin
      wl_mem[in_ch.wall_slot] <= in_ch.wall_x;
      wt_mem[in_ch.wall_slot] <= in_ch.wall_y;
      ww_mem[in_ch.wall_slot] <= in_ch.wall_w;
      wh_mem[in_ch.wall_slot] <= in_ch.wall_h;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ov_r    <= 1'b0;
    end else begin
      prod_r <= mul_a * mul_b;
      if (state_r == S_DONE && out_free) ov_r <= 1'b1;
      else if (ov_r && out_ch.ready)      ov_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (in_ch.valid && in_ch.kind) begin
            px_r    <= PW'(in_ch.centre_x);
            py_r    <= PW'(in_ch.centre_y);
            wi_r    <= '0;
            state_r <= S_WALL;
          end
        end
        S_WALL: begin
          if (wi_r == n_walls) begin
            state_r <= S_BORD;
          end else begin
            dx_r    <= DW'(nx) - DW'(px_r);
            dy_r    <= DW'(ny) - DW'(py_r);
            axis_r  <= 1'b0;
            state_r <= S_CHK;
          end
        end
        S_CHK: begin
          // drop walls whose nearest point is a full radius away on either axis
          if (ax >= DW'(cfg.radius) || ay >= DW'(cfg.radius)) begin
            wi_r    <= wi_r + 1'b1;
            state_r <= S_WALL;
          end else begin
            state_r <= S_SQX;
          end
        end
        S_SQX: state_r <= S_SQY;
        S_SQY: begin
          acc_r   <= prod_r;
          state_r <= S_SUM;
        end
        S_SUM: begin
          acc_r   <= acc_r + prod_r;
          state_r <= S_CMP;
        end
        S_CMP: begin
          if (acc_r == '0 || acc_r >= prod_r) begin
            wi_r    <= wi_r + 1'b1;
            state_r <= S_WALL;
          end else begin
            sq_src_r <= acc_r[31:0];
            sq_rem_r <= '0;
            root_r   <= '0;
            cnt_r    <= 6'd16;
            state_r  <= S_SQRT;
          end
        end
        S_SQRT: begin
          sq_src_r <= {sq_src_r[29:0], 2'b00};
          if (sq_sh >= sq_trial) begin
            sq_rem_r <= sq_sh - sq_trial;
            root_r   <= {root_r[RADIUS_BITS-2:0], 1'b1};
          end else begin
            sq_rem_r <= sq_sh;
            root_r   <= {root_r[RADIUS_BITS-2:0], 1'b0};
          end
          cnt_r <= cnt_r - 1'b1;
          if (cnt_r == 6'd1) state_r <= S_MUL;
        end
        S_MUL: state_r <= S_DSET;
        S_DSET: begin
          // round to nearest, ties away from zero
          num_r   <= prod_r + MW'(root_r >> 1);
          drem_r  <= '0;
          cnt_r   <= 6'(MW);
          state_r <= S_DIV;
        end
        S_DIV: begin
          if (d_sh >= {1'b0, root_r}) begin
            drem_r <= d_sh - {1'b0, root_r};
            num_r  <= {num_r[MW-2:0], 1'b1};
          end else begin
            drem_r <= d_sh;
            num_r  <= {num_r[MW-2:0], 1'b0};
          end
          cnt_r <= cnt_r - 1'b1;
          if (cnt_r == 6'd1) state_r <= S_APPLY;
        end
        S_APPLY: begin
          if (!axis_r) begin
            px_r    <= dx_r[DW-1] ? px_r + q_s : px_r - q_s;
            axis_r  <= 1'b1;
            state_r <= S_MUL;
          end else begin
            py_r    <= dy_r[DW-1] ? py_r + q_s : py_r - q_s;
            wi_r    <= wi_r + 1'b1;
            state_r <= S_WALL;
          end
        end
        S_BORD: begin
          rx_r <= (kx > SAT_HI) ? COORD_BITS'(SAT_HI) :
                  (kx < SAT_LO) ? COORD_BITS'(SAT_LO) : COORD_BITS'(kx);
          ry_r <= (ky > SAT_HI) ? COORD_BITS'(SAT_HI) :
                  (ky < SAT_LO) ? COORD_BITS'(SAT_LO) : COORD_BITS'(ky);
          state_r <= S_DONE;
        end
        S_DONE: begin
          if (out_free) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Result register: hold the last answer until the next one replaces it
  logic signed [COORD_BITS-1:0] ox_r, oy_r;
  always_ff @(posedge clk) begin
    if (state_r == S_DONE && out_free) begin
      ox_r <= rx_r;
      oy_r <= ry_r;
    end
  end

  assign in_ch.ready       = (state_r == S_IDLE);
  assign out_ch.valid      = ov_r;
  assign out_ch.resolved_x = ox_r;
  assign out_ch.resolved_y = oy_r;
endmodule
`default_nettype wire
